// ===== sv/lzssdn_pkg.sv =====
// types and constants shared by the lzss decoder core
// no dependencies
package lzssdn_pkg;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_LOAD,
        S_OUT
    } state_t;

    typedef logic [1:0] phase_t;

    localparam phase_t PHASE_FLAG = 2'd0;
    localparam phase_t PHASE_BYTE = 2'd1;
    localparam phase_t PHASE_HIGH = 2'd2;

    localparam int unsigned COUNT_W = 5;

    localparam logic [11:0]        WINDOW_START = 12'hFEE;
    localparam logic [8:0]         FLAG_MARK    = 9'h100;
    localparam logic [COUNT_W-1:0] MATCH_MIN    = 5'd3;

endpackage

// ===== sv/lzss_decoder_negated_length_core.sv =====
// lzss decoder core, 4096 byte history window, inverted match lengths
// depends on lzssdn_pkg
//
// usage:
//   in_valid/in_ready carries one compressed byte per transaction (flag,
//   literal, or match byte). out_valid/out_ready carries one decompressed byte
//   with last_of_run (final byte caused by that input byte) and stream_done
//   (byte that reaches output_length). cfg_we/cfg_wdata sets output_length.
// timing:
//   after reset the window is cleared to zero, one entry a cycle, and the
//   block takes no input until the clear is done; config writes are taken
//   meanwhile. a literal's output is valid in the cycle after acceptance.
//   each byte of a match (3 to 18 bytes) passes through a window read, a
//   load and an output step, all through the window's one write and one
//   read port and one shared address incrementer.
//   input after output_length is reached is accepted and dropped.
// stalls:
//   a byte waits in the output register while out_ready is low; in_ready
//   stays low until the current input byte's outputs are all taken.
module lzss_decoder_negated_length_core #(
    parameter int unsigned WINDOW_DEPTH = 4096,
    parameter int unsigned LENGTH_WIDTH = 24
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_we,
    input  logic [LENGTH_WIDTH-1:0] cfg_wdata,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [7:0]              in_byte,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [7:0]              out_byte,
    output logic                    last_of_run,
    output logic                    stream_done
);
    import lzssdn_pkg::*;

    localparam int unsigned ADDR_W = $clog2(WINDOW_DEPTH);

    logic [7:0] mem [WINDOW_DEPTH];

    state_t state_reg, state_next;
    logic [ADDR_W-1:0] pos_reg, pos_next;
    logic [ADDR_W-1:0] wpos_reg, wpos_next;
    logic [COUNT_W-1:0] cnt_reg, cnt_next;
    logic [8:0] flag_reg, flag_next;
    phase_t phase_reg, phase_next;
    logic [7:0] held_reg, held_next;
    logic [LENGTH_WIDTH-1:0] emitted_reg, emitted_next;
    logic [LENGTH_WIDTH-1:0] length_reg;
    logic out_valid_reg, out_valid_next;
    logic [7:0] out_byte_reg, out_byte_next;
    logic last_reg, last_next;
    logic done_reg, done_next;
    logic [7:0] rd_data_reg;

    logic mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [7:0] mem_wdata;
    logic [ADDR_W-1:0] inc_in, inc_out;
    logic [LENGTH_WIDTH-1:0] emitted_inc;
    logic hits_len, finished, in_fire, out_fire, literal_go;
    logic [8:0] flag_shifted;

    // shared address incrementer: read pointer, clear pointer or write pointer
    assign inc_out     = inc_in + ADDR_W'(1);
    assign emitted_inc = emitted_reg + LENGTH_WIDTH'(1);
    assign hits_len    = (emitted_inc == length_reg);
    assign finished    = (emitted_reg >= length_reg);
    assign in_fire     = in_valid && in_ready;
    assign out_fire    = out_valid_reg && out_ready;
    assign literal_go  = (phase_reg == PHASE_BYTE) && flag_reg[0];
    assign flag_shifted = flag_reg >> 1;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                if (pos_reg == {ADDR_W{1'b1}})
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (in_fire && !finished)
                begin
                    if (literal_go)
                        state_next = S_OUT;
                    else if (phase_reg == PHASE_HIGH)
                        state_next = S_READ;
                end
            end
            S_READ:  state_next = S_LOAD;
            S_LOAD:  state_next = S_OUT;
            S_OUT:
            begin
                if (out_ready)
                    state_next = last_reg ? S_IDLE : S_READ;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // control outputs
    always_comb
    begin
        in_ready  = (state_reg == S_IDLE);
        mem_we    = 1'b0;
        mem_waddr = wpos_reg;
        mem_wdata = in_byte;
        inc_in    = wpos_reg;
        case (state_reg)
            S_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = pos_reg;
                mem_wdata = 8'd0;
                inc_in    = pos_reg;
            end
            S_IDLE:
            begin
                mem_we = in_fire && !finished && literal_go;
            end
            S_READ:
            begin
                inc_in = pos_reg;
            end
            S_LOAD:
            begin
                mem_we    = 1'b1;
                mem_wdata = rd_data_reg;
            end
            default: ;
        endcase
    end

    // datapath
    always_comb
    begin
        pos_next       = pos_reg;
        wpos_next      = wpos_reg;
        cnt_next       = cnt_reg;
        flag_next      = flag_reg;
        phase_next     = phase_reg;
        held_next      = held_reg;
        emitted_next   = emitted_reg;
        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        last_next      = last_reg;
        done_next      = done_reg;
        case (state_reg)
            S_CLEAR:
            begin
                pos_next = inc_out;
            end
            S_IDLE:
            begin
                if (in_fire && !finished)
                begin
                    case (phase_reg)
                        PHASE_BYTE:
                        begin
                            if (flag_reg[0])
                            begin
                                wpos_next      = inc_out;
                                emitted_next   = emitted_inc;
                                out_valid_next = 1'b1;
                                out_byte_next  = in_byte;
                                last_next      = 1'b1;
                                done_next      = hits_len;
                            end
                            else
                            begin
                                held_next  = in_byte;
                                phase_next = PHASE_HIGH;
                            end
                        end
                        PHASE_HIGH:
                        begin
                            pos_next = ADDR_W'({in_byte[7:4], held_reg});
                            cnt_next = COUNT_W'({1'b0, ~in_byte[3:0]}) + MATCH_MIN;
                        end
                        default:
                        begin
                            flag_next  = FLAG_MARK | {1'b0, in_byte};
                            phase_next = PHASE_BYTE;
                        end
                    endcase
                end
            end
            S_READ:
            begin
                pos_next = inc_out;
            end
            S_LOAD:
            begin
                wpos_next      = inc_out;
                emitted_next   = emitted_inc;
                cnt_next       = cnt_reg - COUNT_W'(1);
                out_valid_next = 1'b1;
                out_byte_next  = rd_data_reg;
                last_next      = (cnt_reg == COUNT_W'(1)) || hits_len;
                done_next      = hits_len;
            end
            S_OUT:
            begin
                if (out_ready)
                begin
                    out_valid_next = 1'b0;
                    // step to the next flag once this input byte is finished
                    if (last_reg)
                    begin
                        flag_next  = flag_shifted;
                        phase_next = (flag_shifted <= 9'd1) ? PHASE_FLAG : PHASE_BYTE;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            pos_reg       <= '0;
            wpos_reg      <= ADDR_W'(WINDOW_START);
            cnt_reg       <= '0;
            flag_reg      <= '0;
            phase_reg     <= PHASE_FLAG;
            held_reg      <= '0;
            emitted_reg   <= '0;
            length_reg    <= '0;
            out_valid_reg <= 1'b0;
            last_reg      <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            wpos_reg      <= wpos_next;
            cnt_reg       <= cnt_next;
            flag_reg      <= flag_next;
            phase_reg     <= phase_next;
            held_reg      <= held_next;
            emitted_reg   <= emitted_next;
            out_valid_reg <= out_valid_next;
            last_reg      <= last_next;
            done_reg      <= done_next;
            if (cfg_we)
                length_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        out_byte_reg <= out_byte_next;
    end

    // window memory, one write and one registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[pos_reg];
    end

    assign out_valid   = out_valid_reg;
    assign out_byte    = out_byte_reg;
    assign last_of_run = last_reg;
    assign stream_done = done_reg;

    a_out_in_out_state: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (state_reg == S_OUT))
        else $error("output valid outside output state");

    a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && done_reg) |-> last_reg)
        else $error("stream_done without last_of_run");

    a_last_returns_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (out_fire && last_reg) |=> (state_reg == S_IDLE))
        else $error("run end did not return to idle");

    a_read_has_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_READ) |-> (cnt_reg != '0))
        else $error("window read with no bytes left in match");

    a_load_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LOAD) |-> ($past(state_reg) == S_READ))
        else $error("load without preceding window read");

endmodule
